/* src/spq_pkg.sv */
// spq_pkg: shared types and codes for the sorted insert priority queue
// used by spq_cell and sorted_insert_priority_queue; no dependencies
package spq_pkg;

    // action codes carried in s_tuser
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // fault codes reported with each result
    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_FULL  = 2'd1,
        FAULT_EMPTY = 2'd2
    } spq_fault_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;   // insert the new entry, queue not full
        logic pop;    // shift everything one place toward the head
    } spq_ctrl_t;

endpackage

/* src/sorted_insert_priority_queue.sv */
// sorted_insert_priority_queue: bounded task queue kept sorted by run time
// top level, a row of spq_cell slots plus fill count and output register
// depends on spq_pkg and spq_cell
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+------------------------------------------
// s_      | in  | s_tvalid/s_tready  | tuser: action; tdata: task_id, run_time
// m_      | out | m_tvalid/m_tready  | tuser: head_valid, fault;
//         |     |                    | tdata: head_task, head_time, fill
//
// one transaction per clock while s_tready is high: every slot compares its key
// with the incoming key in parallel and shifts in the same cycle, the result is
// registered and appears in the cycle after the input transaction
// aresetn (synchronous, active low) empties the queue and the output register
// s_tready is high whenever the output register is empty or being drained
module sorted_insert_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,     // [0] action
    // task_id, run_time, zero pad
    input  logic [((ID_BITS + KEY_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2:0]          m_tuser,     // [0] head_valid, [2:1] fault
    // head_task, head_time, fill, zero pad
    output logic [((ID_BITS + KEY_BITS + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int M_DATA_W = ((ID_BITS + KEY_BITS + CNT_W + 7) / 8) * 8;
    localparam int M_PAD    = M_DATA_W - ID_BITS - KEY_BITS - CNT_W;

    logic                 in_xfer;
    logic                 is_pop;
    logic [ID_BITS-1:0]   new_id;
    logic [KEY_BITS-1:0]  new_key;
    logic                 full;
    logic                 empty;
    spq_pkg::spq_ctrl_t   ctrl;
    spq_pkg::spq_fault_t  fault;

    logic [CNT_W-1:0]     count_reg, count_next;

    logic [QUEUE_DEPTH-1:0] slot_valid;
    logic [QUEUE_DEPTH-1:0] gt;
    logic [ID_BITS-1:0]     id_q  [QUEUE_DEPTH];
    logic [KEY_BITS-1:0]    key_q [QUEUE_DEPTH];

    logic [ID_BITS-1:0]   head_id;
    logic [KEY_BITS-1:0]  head_key;

    logic                 m_valid_reg, m_valid_next;
    logic                 head_valid_reg;
    logic [ID_BITS-1:0]   head_task_reg;
    logic [KEY_BITS-1:0]  head_time_reg;
    logic [CNT_W-1:0]     fill_reg;
    spq_pkg::spq_fault_t  fault_reg;

    // input unpacking and handshake
    assign s_tready = !m_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign is_pop   = (s_tuser == spq_pkg::ACT_POP);
    assign new_id   = s_tdata[ID_BITS-1:0];
    assign new_key  = s_tdata[ID_BITS +: KEY_BITS];

    // command decode
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign ctrl.push = in_xfer && !is_pop && !full;
    assign ctrl.pop  = in_xfer && is_pop && !empty;

    always_comb begin
        fault = spq_pkg::FAULT_NONE;
        if (is_pop && empty) begin
            fault = spq_pkg::FAULT_EMPTY;
        end else if (!is_pop && full) begin
            fault = spq_pkg::FAULT_FULL;
        end
    end

    // fill count
    always_comb begin
        count_next = count_reg;
        if (ctrl.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // row of slots, slot 0 is the head
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
        assign slot_valid[i] = (count_reg > CNT_W'(i));

        spq_cell #(
            .KEY_BITS (KEY_BITS),
            .ID_BITS  (ID_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .slot_valid (slot_valid[i]),
            .new_id     (new_id),
            .new_key    (new_key),
            .left_gt    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
            .left_id    (id_q[(i == 0) ? 0 : i - 1]),
            .left_key   (key_q[(i == 0) ? 0 : i - 1]),
            .right_id   (id_q[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .right_key  (key_q[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .gt         (gt[i]),
            .entry_id   (id_q[i]),
            .entry_key  (key_q[i])
        );
    end

    // head entry after this transaction
    always_comb begin
        head_id  = id_q[0];
        head_key = key_q[0];
        if (ctrl.pop) begin
            head_id  = id_q[1];
            head_key = key_q[1];
        end else if (ctrl.push && gt[0]) begin
            head_id  = new_id;
            head_key = new_key;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_xfer) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            head_valid_reg <= (count_next != '0);
            head_task_reg  <= (count_next != '0) ? head_id : '0;
            head_time_reg  <= (count_next != '0) ? head_key : '0;
            fill_reg       <= count_next;
            fault_reg      <= fault;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {fault_reg, head_valid_reg};
    assign m_tdata  = {{M_PAD{1'b0}}, fill_reg, head_time_reg, head_task_reg};

    // assertions
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted push did not raise the fill count");

    a_full_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && fault_reg == spq_pkg::FAULT_FULL)
            |-> fill_reg == CNT_W'(QUEUE_DEPTH))
        else $error("full fault reported on a queue that is not full");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (key_q[0] <= key_q[1]))
        else $error("head entry is later than its successor");

    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !head_valid_reg)
            |-> (fill_reg == '0 && head_task_reg == '0 && head_time_reg == '0))
        else $error("empty result carries a nonzero head or fill");

endmodule

/* src/spq_cell.sv */
// spq_cell: one slot of the sorted queue, holds a task id and its run time
// compares its key with the incoming key and trades entries with its neighbors
// depends on spq_pkg
module spq_cell #(
    parameter int KEY_BITS = 16,
    parameter int ID_BITS  = 8
) (
    input  logic                 aclk,
    input  spq_pkg::spq_ctrl_t   ctrl,
    input  logic                 slot_valid,   // slot index below the fill count
    input  logic [ID_BITS-1:0]   new_id,
    input  logic [KEY_BITS-1:0]  new_key,
    input  logic                 left_gt,      // neighbor toward head makes way
    input  logic [ID_BITS-1:0]   left_id,
    input  logic [KEY_BITS-1:0]  left_key,
    input  logic [ID_BITS-1:0]   right_id,
    input  logic [KEY_BITS-1:0]  right_key,
    output logic                 gt,           // this slot moves for the new entry
    output logic [ID_BITS-1:0]   entry_id,
    output logic [KEY_BITS-1:0]  entry_key
);

    logic [ID_BITS-1:0]  id_reg,  id_next;
    logic [KEY_BITS-1:0] key_reg, key_next;

    // empty slots and strictly later keys give way, so equal keys stay in order
    assign gt = !slot_valid || (key_reg > new_key);

    // choose own entry, new entry or a neighbor's entry
    always_comb begin
        id_next  = id_reg;
        key_next = key_reg;
        if (ctrl.pop) begin
            id_next  = right_id;
            key_next = right_key;
        end else if (ctrl.push && gt) begin
            if (left_gt) begin
                id_next  = left_id;
                key_next = left_key;
            end else begin
                id_next  = new_id;
                key_next = new_key;
            end
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge aclk) begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign entry_id  = id_reg;
    assign entry_key = key_reg;

endmodule
